// ----- rtl/core/lsth_pkg.sv -----
package lsth_pkg;

   localparam int FRAME_LEN   = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // input opcodes
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_OPEN  = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // status codes
   localparam logic [2:0] ST_NONE      = 3'd0;
   localparam logic [2:0] ST_CONNECTED = 3'd1;
   localparam logic [2:0] ST_BAD_FRAME = 3'd2;
   localparam logic [2:0] ST_TIMEOUT   = 3'd3;
   localparam logic [2:0] ST_CLOSED    = 3'd4;
   localparam logic [2:0] ST_IGNORED   = 3'd5;

   // configuration register indexes
   localparam logic [2:0] REG_ROLE    = 3'd0;
   localparam logic [2:0] REG_FLAG    = 3'd1;
   localparam logic [2:0] REG_ADDRESS = 3'd2;
   localparam logic [2:0] REG_SET     = 3'd3;
   localparam logic [2:0] REG_UA      = 3'd4;
   localparam logic [2:0] REG_DISC    = 3'd5;
   localparam logic [2:0] REG_TIMEOUT = 3'd6;

   localparam logic       ROLE_TX = 1'b0;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TX_WAIT_UA,
      PH_RX_WAIT_SET,
      PH_UP,
      PH_TX_WAIT_DISC,
      PH_RX_WAIT_DISC,
      PH_RX_WAIT_UA
   } phase_type;

   typedef struct packed {
      logic        role;
      logic [7:0]  flag_byte;
      logic [7:0]  address_byte;
      logic [7:0]  set_code;
      logic [7:0]  ua_code;
      logic [7:0]  disc_code;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // one queued job: either a single report word or a full frame
   typedef struct packed {
      logic       is_frame;
      logic [7:0] control;
      logic [2:0] status;
      logic       link_up;
   } job_type;

endpackage

// ----- rtl/core/lsth_front.sv -----
module lsth_front
   import lsth_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_line_byte,
   input  cfg_type    cfg,
   input  logic       q_full,
   output logic       push,
   output job_type    push_job
);

   phase_type             phase_ff, phase_in;
   logic [2:0]            pos_ff, pos_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [7:0]            store_ff [4];
   logic                  store_we;
   logic                  accept;
   logic                  waiting;
   logic                  good;
   logic                  emit;
   job_type               job;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign waiting   = (phase_ff != PH_IDLE) && (phase_ff != PH_UP);
   assign good      = (store_ff[0] == cfg.flag_byte) && (store_ff[1] == cfg.address_byte) &&
                      (req_line_byte == cfg.flag_byte) &&
                      (store_ff[3] == (store_ff[1] ^ store_ff[2]));

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      timer_in     = timer_ff;
      store_we     = 1'b0;
      emit         = 1'b0;
      job.is_frame = 1'b0;
      job.control  = 8'd0;
      job.status   = ST_NONE;
      case (req_opcode)
         OP_BYTE: begin
            if (waiting) begin
               if (pos_ff < 3'd4) begin
                  store_we = 1'b1;
                  pos_in   = pos_ff + 3'd1;
               end else begin
                  pos_in = 3'd0;
                  case (phase_ff)
                     PH_TX_WAIT_UA: begin
                        emit = 1'b1;
                        if (good && store_ff[2] == cfg.ua_code) begin
                           phase_in   = PH_UP;
                           job.status = ST_CONNECTED;
                        end else begin
                           phase_in   = PH_IDLE;
                           job.status = ST_BAD_FRAME;
                        end
                     end
                     PH_RX_WAIT_SET: begin
                        emit = 1'b1;
                        if (good && store_ff[2] == cfg.set_code) begin
                           phase_in     = PH_UP;
                           job.is_frame = 1'b1;
                           job.control  = cfg.ua_code;
                           job.status   = ST_CONNECTED;
                        end else begin
                           phase_in   = PH_IDLE;
                           job.status = ST_BAD_FRAME;
                        end
                     end
                     PH_TX_WAIT_DISC: begin
                        if (good && store_ff[2] == cfg.disc_code) begin
                           emit         = 1'b1;
                           phase_in     = PH_IDLE;
                           job.is_frame = 1'b1;
                           job.control  = cfg.ua_code;
                           job.status   = ST_CLOSED;
                        end
                     end
                     PH_RX_WAIT_DISC: begin
                        if (good && store_ff[2] == cfg.disc_code) begin
                           emit         = 1'b1;
                           phase_in     = PH_RX_WAIT_UA;
                           job.is_frame = 1'b1;
                           job.control  = cfg.disc_code;
                        end
                     end
                     PH_RX_WAIT_UA: begin
                        if (good && store_ff[2] == cfg.ua_code) begin
                           emit       = 1'b1;
                           phase_in   = PH_IDLE;
                           job.status = ST_CLOSED;
                        end
                     end
                     default: begin
                        emit = 1'b0;
                     end
                  endcase
               end
            end
         end
         OP_OPEN: begin
            if (phase_ff != PH_IDLE) begin
               emit       = 1'b1;
               job.status = ST_IGNORED;
            end else begin
               pos_in = 3'd0;
               if (cfg.role == ROLE_TX) begin
                  phase_in     = PH_TX_WAIT_UA;
                  timer_in     = TIMER_BITS'(cfg.timeout_ticks);
                  emit         = 1'b1;
                  job.is_frame = 1'b1;
                  job.control  = cfg.set_code;
               end else begin
                  phase_in = PH_RX_WAIT_SET;
               end
            end
         end
         OP_CLOSE: begin
            if (phase_ff != PH_UP) begin
               emit       = 1'b1;
               job.status = ST_IGNORED;
            end else begin
               pos_in = 3'd0;
               if (cfg.role == ROLE_TX) begin
                  phase_in     = PH_TX_WAIT_DISC;
                  emit         = 1'b1;
                  job.is_frame = 1'b1;
                  job.control  = cfg.disc_code;
               end else begin
                  phase_in = PH_RX_WAIT_DISC;
               end
            end
         end
         OP_TICK: begin
            if (phase_ff == PH_TX_WAIT_UA) begin
               if (timer_ff <= TIMER_BITS'(1)) begin
                  timer_in   = '0;
                  phase_in   = PH_IDLE;
                  pos_in     = 3'd0;
                  emit       = 1'b1;
                  job.status = ST_TIMEOUT;
               end else begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      job.link_up = (phase_in == PH_UP) || (phase_in == PH_TX_WAIT_DISC) ||
                    (phase_in == PH_RX_WAIT_DISC) || (phase_in == PH_RX_WAIT_UA);
   end

   assign push     = accept && emit;
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= 3'd0;
         timer_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_we) begin
         store_ff[pos_ff[1:0]] <= req_line_byte;
      end
   end

endmodule

// ----- rtl/core/lsth_queue.sv -----
module lsth_queue
   import lsth_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QUEUE_PTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QUEUE_PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/lsth_back.sv -----
module lsth_back
   import lsth_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  job_type    head,
   input  logic       q_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_valid,
   output logic       rsp_last,
   output logic [2:0] rsp_status,
   output logic       rsp_link_up
);

   job_type    cur_ff, cur_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       txv_ff, txv_in;
   logic       last_ff, last_in;
   logic [2:0] status_ff, status_in;
   logic       up_ff, up_in;
   logic       out_free;
   logic       load;
   job_type    sel_job;
   logic [2:0] sel_idx;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      pop      = 1'b0;
      load     = 1'b0;
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      sel_job  = cur_ff;
      sel_idx  = cnt_ff;
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = 1'b0;
         if (cnt_ff != 3'd0) begin
            // continue the frame in progress
            load   = 1'b1;
            cnt_in = (cnt_ff == 3'(FRAME_LEN - 1)) ? 3'd0 : cnt_ff + 3'd1;
         end else if (!q_empty) begin
            pop     = 1'b1;
            load    = 1'b1;
            cur_in  = head;
            sel_job = head;
            sel_idx = 3'd0;
            cnt_in  = head.is_frame ? 3'd1 : 3'd0;
         end
         if (load) begin
            valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      byte_in = 8'd0;
      if (sel_job.is_frame) begin
         case (sel_idx)
            3'd0:    byte_in = cfg.flag_byte;
            3'd1:    byte_in = cfg.address_byte;
            3'd2:    byte_in = sel_job.control;
            3'd3:    byte_in = cfg.address_byte ^ sel_job.control;
            default: byte_in = cfg.flag_byte;
         endcase
      end
      txv_in    = sel_job.is_frame;
      last_in   = !sel_job.is_frame || (sel_idx == 3'(FRAME_LEN - 1));
      status_in = last_in ? sel_job.status : ST_NONE;
      up_in     = sel_job.link_up;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load) begin
         byte_ff   <= byte_in;
         txv_ff    <= txv_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         up_ff     <= up_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_tx_byte  = byte_ff;
   assign rsp_tx_valid = txv_ff;
   assign rsp_last     = last_ff;
   assign rsp_status   = status_ff;
   assign rsp_link_up  = up_ff;

endmodule

// ----- rtl/core/link_setup_teardown_handshake.sv -----
// The first result word of an item goes through the queue and then the output register;
// items that cause no result finish in the cycle they are accepted. Throughput: one item
// per cycle into the front while the queue is not full; the back sends one word per cycle
// while rsp_stall is low, so a five-word frame holds the back; a four-job queue absorbs it.
// Reset (synchronous, active high): link idle, frame position and timer cleared, queue
// and output emptied, configuration registers back to their defaults.
module link_setup_teardown_handshake
   import lsth_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_line_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_valid,
   output logic        rsp_last,
   output logic [2:0]  rsp_status,
   output logic        rsp_link_up,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    push;
   job_type push_job;
   logic    pop;
   job_type head;
   logic    q_empty;
   logic    q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.role          <= 1'b0;
         cfg_ff.flag_byte     <= 8'd126;
         cfg_ff.address_byte  <= 8'd3;
         cfg_ff.set_code      <= 8'd3;
         cfg_ff.ua_code       <= 8'd7;
         cfg_ff.disc_code     <= 8'd11;
         cfg_ff.timeout_ticks <= 16'd3;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROLE:    cfg_ff.role          <= csr_wdata[0];
            REG_FLAG:    cfg_ff.flag_byte     <= csr_wdata[7:0];
            REG_ADDRESS: cfg_ff.address_byte  <= csr_wdata[7:0];
            REG_SET:     cfg_ff.set_code      <= csr_wdata[7:0];
            REG_UA:      cfg_ff.ua_code       <= csr_wdata[7:0];
            REG_DISC:    cfg_ff.disc_code     <= csr_wdata[7:0];
            REG_TIMEOUT: cfg_ff.timeout_ticks <= csr_wdata;
            default:     cfg_ff.role          <= cfg_ff.role;
         endcase
      end
   end

   lsth_front #(
      .TIMER_BITS(TIMER_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_line_byte (req_line_byte),
      .cfg           (cfg_ff),
      .q_full        (q_full),
      .push          (push),
      .push_job      (push_job)
   );

   lsth_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   lsth_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (head),
      .q_empty      (q_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_tx_valid (rsp_tx_valid),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status),
      .rsp_link_up  (rsp_link_up)
   );

endmodule
